[rtl/core/kvm_hotkey_switch_router_macros.svh]
// Assertion macros for the KVM hotkey switch router.
`ifndef KVM_HOTKEY_SWITCH_ROUTER_MACROS_SVH
`define KVM_HOTKEY_SWITCH_ROUTER_MACROS_SVH

`ifndef SYNTH
`define KHSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kvm hotkey switch router check failed");
`define KHSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kvm hotkey switch router check failed");
`else
`define KHSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define KHSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/kvm_hsr_pkg.sv]
// Types and constants shared by the KVM hotkey switch router modules.
package kvm_hsr_pkg;

  localparam logic [4:0] EVT_KEY = 5'd1;
  localparam logic [4:0] EVT_MSC = 5'd4;
  localparam logic [4:0] EVT_LED = 5'd17;

  localparam logic [9:0] KEY_CAPS   = 10'd58;
  localparam logic [9:0] KEY_NUM    = 10'd69;
  localparam logic [9:0] KEY_SCROLL = 10'd70;

  localparam logic [9:0] LED_NUM  = 10'd0;
  localparam logic [9:0] LED_CAPS = 10'd1;

  localparam logic [2:0] TGT_KBD   = 3'd0;
  localparam logic [2:0] TGT_MOUSE = 3'd2;
  localparam logic [2:0] TGT_LED   = 3'd4;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_TAP_WINDOW = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLDOFF    = 2'd1;

  localparam logic [15:0] TAP_WINDOW_RST = 16'd1000;
  localparam logic [15:0] HOLDOFF_RST    = 16'd500;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic               is_mouse;
    logic               console_active;
    logic               refresh_request;
    logic [4:0]         ev_type;
    logic [9:0]         ev_code;
    logic signed [31:0] ev_value;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         target;
    logic [4:0]         out_type;
    logic [9:0]         out_code;
    logic signed [31:0] out_value;
  } result_t;

  typedef struct packed {
    logic [15:0] tap_window_ms;
    logic [15:0] switch_holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                     count;
    result_t [MaxResults-1:0]       entry;
  } load_t;

endpackage

[rtl/core/kvm_hsr_cfg.sv]
// Configuration registers of the KVM hotkey switch router.
module kvm_hsr_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [kvm_hsr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [15:0]                         cfg_data_i,
  output kvm_hsr_pkg::cfg_t                   cfg_o
);
  import kvm_hsr_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_window_ms     <= TAP_WINDOW_RST;
      cfg_q.switch_holdoff_ms <= HOLDOFF_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TAP_WINDOW: cfg_q.tap_window_ms     <= cfg_data_i;
        CFG_HOLDOFF:    cfg_q.switch_holdoff_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/kvm_hsr_core.sv]
// Routing state and per-item decision logic of the KVM hotkey switch router.
module kvm_hsr_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kvm_hsr_pkg::in_item_t item_i,
  input  logic                  fire_i,
  input  kvm_hsr_pkg::cfg_t     cfg_i,
  output kvm_hsr_pkg::load_t    load_o
);
  import kvm_hsr_pkg::*;

  logic        dest_q, dest_d;
  logic [1:0]  num_lock_q, num_lock_d;
  logic [1:0]  caps_lock_q, caps_lock_d;
  logic        num_shown_q, num_shown_d;
  logic        caps_shown_q, caps_shown_d;
  logic [31:0] last_tap_q, last_tap_d;
  logic [31:0] last_sw_q, last_sw_d;
  logic        refresh_q, refresh_d;

  logic        refresh;
  logic        drop;
  logic        kbd;
  logic        press;
  logic        scroll_press;
  logic        num_press;
  logic        caps_press;
  logic [32:0] now_ext;
  logic [32:0] tap_lim;
  logic [32:0] hold_lim;
  logic        do_switch;
  logic        dest_new;
  logic        num_cur;
  logic        caps_cur;
  logic        num_led;
  logic        caps_led;
  result_t     fwd_res;
  result_t     num_res;
  result_t     caps_res;

  always_comb begin
    refresh      = refresh_q | item_i.refresh_request;
    drop         = (item_i.ev_type == EVT_MSC) || !item_i.console_active;
    kbd          = !drop && !item_i.is_mouse;
    press        = (item_i.ev_type == EVT_KEY) && (item_i.ev_value == 32'sd1);
    scroll_press = kbd && press && (item_i.ev_code == KEY_SCROLL);
    num_press    = kbd && press && (item_i.ev_code == KEY_NUM);
    caps_press   = kbd && press && (item_i.ev_code == KEY_CAPS);

    now_ext  = {1'b0, item_i.now_ms};
    tap_lim  = {1'b0, last_tap_q} + {17'b0, cfg_i.tap_window_ms};
    hold_lim = {1'b0, last_sw_q} + {17'b0, cfg_i.switch_holdoff_ms};
    do_switch = scroll_press && (now_ext < tap_lim) && (now_ext > hold_lim);
    dest_new  = dest_q ^ do_switch;

    num_cur  = num_lock_q[dest_new] ^ num_press;
    caps_cur = caps_lock_q[dest_new] ^ caps_press;
    num_led  = kbd && ((num_shown_q != num_cur) || refresh);
    caps_led = kbd && ((caps_shown_q != caps_cur) || refresh);

    fwd_res.target    = item_i.is_mouse ? (TGT_MOUSE | {2'b00, dest_q})
                                        : (TGT_KBD | {2'b00, dest_new});
    fwd_res.out_type  = item_i.ev_type;
    fwd_res.out_code  = item_i.ev_code;
    fwd_res.out_value = item_i.ev_value;

    num_res.target    = TGT_LED;
    num_res.out_type  = EVT_LED;
    num_res.out_code  = LED_NUM;
    num_res.out_value = {31'b0, num_cur};

    caps_res.target    = TGT_LED;
    caps_res.out_type  = EVT_LED;
    caps_res.out_code  = LED_CAPS;
    caps_res.out_value = {31'b0, caps_cur};

    // Results are packed from entry 0 upward: num LED, caps LED, forwarded item.
    load_o.entry[0] = num_led ? num_res : (caps_led ? caps_res : fwd_res);
    load_o.entry[1] = (num_led && caps_led) ? caps_res : fwd_res;
    load_o.entry[2] = fwd_res;
    if (drop) begin
      load_o.count = 2'd0;
    end else begin
      load_o.count = 2'd1 + {1'b0, num_led} + {1'b0, caps_led};
    end

    dest_d       = dest_q;
    num_lock_d   = num_lock_q;
    caps_lock_d  = caps_lock_q;
    num_shown_d  = num_shown_q;
    caps_shown_d = caps_shown_q;
    last_tap_d   = last_tap_q;
    last_sw_d    = last_sw_q;
    refresh_d    = refresh;
    if (kbd) begin
      dest_d                = dest_new;
      num_lock_d[dest_new]  = num_cur;
      caps_lock_d[dest_new] = caps_cur;
      num_shown_d           = num_cur;
      caps_shown_d          = caps_cur;
      refresh_d             = 1'b0;
      if (scroll_press) begin
        last_tap_d = item_i.now_ms;
      end
      if (do_switch) begin
        last_sw_d = item_i.now_ms;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q       <= 1'b0;
      num_lock_q   <= 2'b11;
      caps_lock_q  <= 2'b00;
      num_shown_q  <= 1'b0;
      caps_shown_q <= 1'b0;
      last_tap_q   <= 32'd0;
      last_sw_q    <= 32'd0;
      refresh_q    <= 1'b1;
    end else if (fire_i) begin
      dest_q       <= dest_d;
      num_lock_q   <= num_lock_d;
      caps_lock_q  <= caps_lock_d;
      num_shown_q  <= num_shown_d;
      caps_shown_q <= caps_shown_d;
      last_tap_q   <= last_tap_d;
      last_sw_q    <= last_sw_d;
      refresh_q    <= refresh_d;
    end
  end

endmodule

[rtl/core/kvm_hsr_outbuf.sv]
// Result register bank that hands out the results of one item, one per cycle while the receiver is ready.
module kvm_hsr_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kvm_hsr_pkg::load_t   load_i,
  input  logic                 fire_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output kvm_hsr_pkg::result_t result_o,
  output logic                 last_o,
  output logic                 free_o
);
  import kvm_hsr_pkg::*;

  result_t    entry_q [MaxResults];
  logic [1:0] cnt_q;
  logic [1:0] idx_q;
  logic       pop;
  logic       load;

  assign out_valid_o = (cnt_q != 2'd0);
  assign last_o      = (idx_q == (cnt_q - 2'd1));
  assign result_o    = entry_q[idx_q];
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = !out_valid_o || (pop && last_o);
  assign load        = fire_i && (load_i.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (load) begin
      cnt_q <= load_i.count;
      idx_q <= 2'd0;
    end else if (pop && last_o) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (pop) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < MaxResults; i++) begin
        entry_q[i] <= load_i.entry[i];
      end
    end
  end

endmodule

[rtl/core/kvm_hotkey_switch_router.sv]
// Top level of the KVM hotkey switch router.
//
// Input events arrive on a valid/ready channel and are routed to the keyboard or
// mouse target of one of two destinations, with Scroll Lock double taps switching
// the destination and LED updates sent back to the keyboard. Results leave on a
// second valid/ready channel; last_o marks the final result of each item.
// The two configuration registers are written through a separate valid/ready
// channel that is always ready; writes are expected only while the block is idle.
// An accepted item lands in an input register and is decided once the result
// bank can take its results, which are then registered there and shown on the
// outputs. Each item yields zero to three results, sent one per cycle from the
// bank while the receiver is ready; an item with one result or none can leave
// the input register every cycle while results are taken, and an item with LED
// updates occupies the result bank until all its results are taken. When the
// receiver stalls, the result bank holds and the next item with results waits
// in the input register; the input channel stays ready while that register is
// free. Reset empties both stages and restores the routing state and registers.
`include "kvm_hotkey_switch_router_macros.svh"

module kvm_hotkey_switch_router (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              is_mouse_i,
  input  logic                              console_active_i,
  input  logic                              refresh_request_i,
  input  logic [4:0]                        ev_type_i,
  input  logic [9:0]                        ev_code_i,
  input  logic signed [31:0]                ev_value_i,
  input  logic [31:0]                       now_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        target_o,
  output logic [4:0]                        out_type_o,
  output logic [9:0]                        out_code_o,
  output logic signed [31:0]                out_value_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kvm_hsr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [15:0]                       cfg_data_i
);
  import kvm_hsr_pkg::*;

  in_item_t in_q;
  logic     in_vld_q;
  cfg_t     cfg;
  load_t    load;
  result_t  res;
  logic     buf_free;
  logic     proc_fire;

  assign cfg_ready_o = 1'b1;
  assign proc_fire   = in_vld_q && ((load.count == 2'd0) || buf_free);
  assign in_ready_o  = !in_vld_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (proc_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.is_mouse        <= is_mouse_i;
      in_q.console_active  <= console_active_i;
      in_q.refresh_request <= refresh_request_i;
      in_q.ev_type         <= ev_type_i;
      in_q.ev_code         <= ev_code_i;
      in_q.ev_value        <= ev_value_i;
      in_q.now_ms          <= now_ms_i;
    end
  end

  kvm_hsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kvm_hsr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_q),
    .fire_i (proc_fire),
    .cfg_i  (cfg),
    .load_o (load)
  );

  kvm_hsr_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .fire_i      (proc_fire),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .result_o    (res),
    .last_o      (last_o),
    .free_o      (buf_free)
  );

  assign target_o    = res.target;
  assign out_type_o  = res.out_type;
  assign out_code_o  = res.out_code;
  assign out_value_o = res.out_value;

  `KHSR_ASSERT_IMPL(a_led_not_last, clk_i, rst_ni,
                    out_valid_o && (target_o == TGT_LED), !last_o)
  `KHSR_ASSERT_IMPL(a_mouse_single, clk_i, rst_ni,
                    proc_fire && in_q.is_mouse && (load.count != 2'd0), load.count == 2'd1)
  `KHSR_ASSERT_NEXT(a_load_shows, clk_i, rst_ni,
                    proc_fire && (load.count != 2'd0), out_valid_o)

endmodule

[test/kvm_hotkey_switch_router_tb.sv]
// Self-checking testbench for the KVM hotkey switch router: directed and random events.
module kvm_hotkey_switch_router_tb;
  import kvm_hsr_pkg::*;

  localparam logic [4:0] EVT_REL = 5'd2;
  localparam logic [9:0] KEY_A = 10'd30;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    result_t res;
    logic    last;
  } routed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t ev_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] target;
  logic [4:0] out_type;
  logic [9:0] out_code;
  logic signed [31:0] out_value;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Expected routing state, kept alongside the block.
  logic cur_dest = 1'b0;
  logic [1:0] num_lock = 2'b11;
  logic [1:0] caps_lock = 2'b00;
  logic num_led = 1'b0;
  logic caps_led = 1'b0;
  logic [31:0] tap_ms = '0;
  logic [31:0] switch_ms = '0;
  logic led_resend = 1'b1;
  logic [15:0] tap_limit = TAP_WINDOW_RST;
  logic [15:0] holdoff_limit = HOLDOFF_RST;

  routed_t pending_routes[$];
  int mismatches = 0;
  int in_gap = 0;
  int in_gap_max = 9;
  int out_stall_max = 9;
  int sink_hold = 0;
  logic [31:0] ms_clock = 32'd10000;

  kvm_hotkey_switch_router dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .is_mouse_i       (ev_in.is_mouse),
    .console_active_i (ev_in.console_active),
    .refresh_request_i(ev_in.refresh_request),
    .ev_type_i        (ev_in.ev_type),
    .ev_code_i        (ev_in.ev_code),
    .ev_value_i       (ev_in.ev_value),
    .now_ms_i         (ev_in.now_ms),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .target_o         (target),
    .out_type_o       (out_type),
    .out_code_o       (out_code),
    .out_value_o      (out_value),
    .last_o           (last),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void push_route(logic [2:0] tgt, logic [4:0] typ, logic [9:0] code,
                                     logic signed [31:0] val, logic fin);
    routed_t r;
    r.res.target = tgt;
    r.res.out_type = typ;
    r.res.out_code = code;
    r.res.out_value = val;
    r.last = fin;
    pending_routes.push_back(r);
  endfunction

  function automatic void route_event(in_item_t it);
    logic press;
    logic [32:0] when_ms;
    when_ms = {1'b0, it.now_ms};
    led_resend = led_resend | it.refresh_request;
    if (it.ev_type == EVT_MSC || !it.console_active) return;
    if (it.is_mouse) begin
      push_route(TGT_MOUSE + {2'b00, cur_dest}, it.ev_type, it.ev_code, it.ev_value, 1'b1);
      return;
    end
    press = (it.ev_type == EVT_KEY) && (it.ev_value == 32'sd1);
    if (press && it.ev_code == KEY_SCROLL) begin
      if (when_ms < {1'b0, tap_ms} + {17'd0, tap_limit} &&
          when_ms > {1'b0, switch_ms} + {17'd0, holdoff_limit}) begin
        cur_dest = ~cur_dest;
        switch_ms = it.now_ms;
      end
      tap_ms = it.now_ms;
    end
    if (press && it.ev_code == KEY_NUM) num_lock[cur_dest] = ~num_lock[cur_dest];
    if (num_led != num_lock[cur_dest] || led_resend) begin
      num_led = num_lock[cur_dest];
      push_route(TGT_LED, EVT_LED, LED_NUM, {31'd0, num_led}, 1'b0);
    end
    if (press && it.ev_code == KEY_CAPS) caps_lock[cur_dest] = ~caps_lock[cur_dest];
    if (caps_led != caps_lock[cur_dest] || led_resend) begin
      caps_led = caps_lock[cur_dest];
      push_route(TGT_LED, EVT_LED, LED_CAPS, {31'd0, caps_led}, 1'b0);
    end
    led_resend = 1'b0;
    push_route(TGT_KBD + {2'b00, cur_dest}, it.ev_type, it.ev_code, it.ev_value, 1'b1);
  endfunction

  function automatic in_item_t make_event(logic mouse, logic active, logic refresh,
                                          logic [4:0] typ, logic [9:0] code,
                                          logic [31:0] val, logic [31:0] ms);
    in_item_t it;
    it.is_mouse = mouse;
    it.console_active = active;
    it.refresh_request = refresh;
    it.ev_type = typ;
    it.ev_code = code;
    it.ev_value = val;
    it.now_ms = ms;
    return it;
  endfunction

  task automatic send_event(in_item_t it);
    repeat (in_gap) @(posedge clk);
    in_valid <= 1'b1;
    ev_in <= it;
    do @(posedge clk); while (!in_ready);
    route_event(it);
    in_gap = $urandom_range(0, in_gap_max);
    if (in_gap != 0) in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    if (in_gap == 0) in_valid <= 1'b0;
    in_gap = 0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TAP_WINDOW: tap_limit = data;
      CFG_HOLDOFF:    holdoff_limit = data;
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [15:0] tap, logic [15:0] holdoff);
    write_reg(CFG_TAP_WINDOW, tap);
    write_reg(CFG_HOLDOFF, holdoff);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_events(int count);
    in_item_t it;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      it = make_event(1'b0, 1'b1, $urandom_range(0, 9) == 0, EVT_KEY, KEY_A, 1, $urandom());
      if (kind < 30) begin
        if (kind < 2 && ms_clock > 1000) ms_clock -= $urandom_range(0, 300);
        else ms_clock += $urandom_range(0, 2 * tap_limit);
        it.ev_code = KEY_SCROLL;
        it.now_ms = ms_clock;
      end else if (kind < 42) begin
        it.ev_code = KEY_NUM;
      end else if (kind < 52) begin
        it.ev_code = KEY_CAPS;
      end else if (kind < 60) begin
        case ($urandom_range(0, 2))
          0: it.ev_code = KEY_NUM;
          1: it.ev_code = KEY_CAPS;
          default: it.ev_code = KEY_SCROLL;
        endcase
        it.ev_value = $urandom_range(0, 2);
      end else if (kind < 72) begin
        it.ev_code = 10'($urandom_range(0, 767));
        it.ev_value = $urandom_range(0, 2);
      end else begin
        it.ev_type = 5'($urandom_range(0, 31));
        it.ev_code = 10'($urandom_range(0, 767));
        it.ev_value = $urandom();
        if (kind < 84) it.is_mouse = 1'b1;
        else if (kind < 89) it.ev_type = EVT_MSC;
        else if (kind < 93) it.console_active = 1'b0;
        else it.is_mouse = 1'($urandom_range(0, 1));
      end
      send_event(it);
    end
  endtask

  task automatic test_forwarding_and_drops();
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, KEY_A, 1, 100));
    send_event(make_event(1'b1, 1'b1, 1'b0, EVT_REL, 10'd0, -5, 110));
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_MSC, 10'd4, 32'h7fff_ffff, 120));
    send_event(make_event(1'b0, 1'b0, 1'b1, EVT_KEY, KEY_A, 0, 130));
    send_event(make_event(1'b1, 1'b1, 1'b0, EVT_REL, 10'd1, 7, 140));
    send_event(make_event(1'b0, 1'b1, 1'b0, 5'd31, 10'd767, 32'h8000_0000, 150));
    send_event(make_event(1'b0, 1'b1, 1'b0, 5'd0, 10'd0, 0, 160));
    send_event(make_event(1'b1, 1'b1, 1'b1, 5'd3, 10'h2aa, 32'h5555_5555, 170));
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, 10'h155, 1, 180));
    wait_idle();
  endtask

  task automatic test_lock_keys();
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, KEY_NUM, 1, 200));
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, KEY_CAPS, 1, 210));
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, KEY_NUM, 0, 220));
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, KEY_CAPS, 2, 230));
    wait_idle();
  endtask

  task automatic test_scroll_switching();
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, KEY_SCROLL, 1, 2000));
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, KEY_SCROLL, 1, 2300));
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, KEY_SCROLL, 1, 2600));
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, KEY_SCROLL, 1, 3400));
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, KEY_SCROLL, 2, 3500));
    send_event(make_event(1'b1, 1'b1, 1'b0, EVT_REL, 10'd8, 1, 3600));
    wait_idle();
  endtask

  task automatic test_register_decode();
    write_reg(CFG_SPARE_A, 16'($urandom_range(0, 65535)));
    write_reg(CFG_SPARE_B, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_random_traffic();
    send_random_events(70);
    wait_idle();
    set_timing(16'hffff, 16'd0);
    send_random_events(60);
    wait_idle();
    set_timing(16'd1, 16'hffff);
    send_random_events(30);
    wait_idle();
    set_timing(16'($urandom_range(100, 3000)), 16'($urandom_range(0, 1000)));
    in_gap_max = 0;
    out_stall_max = 0;
    send_random_events(70);
    wait_idle();
    in_gap_max = 9;
    out_stall_max = 9;
  endtask

  task automatic test_backpressure();
    in_gap_max = 0;
    out_stall_max = 3;
    sink_hold = 120;
    send_random_events(24);
    wait_idle();
    in_gap_max = 9;
    out_stall_max = 9;
  endtask

  // Sums near the top of the time range must not wrap.
  task automatic test_time_extremes();
    set_timing(TAP_WINDOW_RST, HOLDOFF_RST);
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, KEY_SCROLL, 1, 32'hffff_ff00));
    send_event(make_event(1'b0, 1'b1, 1'b1, EVT_KEY, KEY_SCROLL, 1, 32'hffff_ffff));
    send_event(make_event(1'b0, 1'b1, 1'b0, EVT_KEY, KEY_SCROLL, 1, 600));
    wait_idle();
  endtask

  initial begin : result_sink
    int hold;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = sink_hold + $urandom_range(0, out_stall_max);
      sink_hold = 0;
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    routed_t got;
    routed_t want;
    if (rst_n && out_valid && out_ready) begin
      got.res.target = target;
      got.res.out_type = out_type;
      got.res.out_code = out_code;
      got.res.out_value = out_value;
      got.last = last;
      if (pending_routes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tgt %0d type %0d code %0d value %0d last %0b",
                   target, out_type, out_code, out_value, last);
      end else begin
        want = pending_routes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want tgt %0d type %0d code %0d value %0d last %0b, got %0d %0d %0d %0d %0b",
                     want.res.target, want.res.out_type, want.res.out_code,
                     want.res.out_value, want.last,
                     target, out_type, out_code, out_value, last);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_forwarding_and_drops();
    test_lock_keys();
    test_scroll_switching();
    test_register_decode();
    test_random_traffic();
    test_backpressure();
    test_time_extremes();
    if (mismatches == 0 && pending_routes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[kvm_hotkey_switch_router.f]
+incdir+rtl/core
rtl/core/kvm_hsr_pkg.sv
rtl/core/kvm_hsr_cfg.sv
rtl/core/kvm_hsr_core.sv
rtl/core/kvm_hsr_outbuf.sv
rtl/core/kvm_hotkey_switch_router.sv
test/kvm_hotkey_switch_router_tb.sv
